// File: design/tked_pkg.sv
// Shared constants for the terminal key event decoder: field widths,
// key codes and the special byte values the decoder matches on.
// No dependencies.
package tked_pkg;

  localparam int BYTE_W = 8;
  localparam int KEY_W  = 5;
  localparam int CHAR_W = 21;
  localparam int LEN_W  = 6;

  localparam int MAX_ESCAPE_LENGTH_DEFAULT = 32;

  localparam logic [KEY_W-1:0] KEY_CHAR  = 5'd0;
  localparam logic [KEY_W-1:0] KEY_UP    = 5'd1;
  localparam logic [KEY_W-1:0] KEY_DOWN  = 5'd2;
  localparam logic [KEY_W-1:0] KEY_RIGHT = 5'd3;
  localparam logic [KEY_W-1:0] KEY_LEFT  = 5'd4;
  localparam logic [KEY_W-1:0] KEY_HOME  = 5'd5;
  localparam logic [KEY_W-1:0] KEY_END   = 5'd6;
  localparam logic [KEY_W-1:0] KEY_TAB   = 5'd7;
  localparam logic [KEY_W-1:0] KEY_INS   = 5'd8;
  localparam logic [KEY_W-1:0] KEY_DEL   = 5'd9;
  localparam logic [KEY_W-1:0] KEY_PGUP  = 5'd10;
  localparam logic [KEY_W-1:0] KEY_PGDN  = 5'd11;
  localparam logic [KEY_W-1:0] KEY_F1    = 5'd12;
  localparam logic [KEY_W-1:0] KEY_F2    = 5'd13;
  localparam logic [KEY_W-1:0] KEY_F3    = 5'd14;
  localparam logic [KEY_W-1:0] KEY_F4    = 5'd15;
  localparam logic [KEY_W-1:0] KEY_F5    = 5'd16;
  localparam logic [KEY_W-1:0] KEY_F6    = 5'd17;
  localparam logic [KEY_W-1:0] KEY_F7    = 5'd18;
  localparam logic [KEY_W-1:0] KEY_F8    = 5'd19;
  localparam logic [KEY_W-1:0] KEY_F9    = 5'd20;
  localparam logic [KEY_W-1:0] KEY_F10   = 5'd21;
  localparam logic [KEY_W-1:0] KEY_F11   = 5'd22;
  localparam logic [KEY_W-1:0] KEY_F12   = 5'd23;
  localparam logic [KEY_W-1:0] KEY_ESC   = 5'd24;
  localparam logic [KEY_W-1:0] KEY_ENTER = 5'd25;
  localparam logic [KEY_W-1:0] KEY_BKSP  = 5'd26;

  localparam logic [BYTE_W-1:0] BYTE_BS  = 8'd8;
  localparam logic [BYTE_W-1:0] BYTE_TAB = 8'd9;
  localparam logic [BYTE_W-1:0] BYTE_LF  = 8'd10;
  localparam logic [BYTE_W-1:0] BYTE_CR  = 8'd13;
  localparam logic [BYTE_W-1:0] BYTE_SUB = 8'd26;
  localparam logic [BYTE_W-1:0] BYTE_ESC = 8'd27;
  localparam logic [BYTE_W-1:0] BYTE_DEL = 8'd127;

  localparam logic [CHAR_W-1:0] CP_MAX       = 21'h10FFFF;
  localparam logic [CHAR_W-1:0] CP_SURR_LOW  = 21'h00D800;
  localparam logic [CHAR_W-1:0] CP_SURR_HIGH = 21'h00DFFF;

endpackage

// File: design/tked_byte_if.sv
// Input channel of the key event decoder: one raw terminal byte per transfer.
// Depends on tked_pkg.
interface tked_byte_if import tked_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// File: design/tked_event_if.sv
// Output channel of the key event decoder: one key event per transfer.
// Depends on tked_pkg.
interface tked_event_if import tked_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  key_code;
  logic [CHAR_W-1:0] character;
  logic              ctrl;
  logic              alt;
  logic              shift;

  modport source (output valid, output key_code, output character,
                  output ctrl, output alt, output shift, input ready);
  modport sink   (input valid, input key_code, input character,
                  input ctrl, input alt, input shift, output ready);
endinterface

// File: design/terminal_key_event_decoder.sv
// Terminal key event decoder: raw terminal bytes in, key events out.
// Depends on tked_pkg, tked_byte_if and tked_event_if.
//
// Usage:
//   key_bytes carries one raw byte per transfer; key_events carries at most
//   one key event (key code, code point, ctrl/alt/shift) per accepted byte.
//   Bytes that only advance an escape or UTF-8 sequence, or that are
//   dropped, give no event.
// Latency and throughput:
//   One byte is accepted every cycle that key_bytes.ready is high. The event
//   a byte causes is offered on key_events in the cycle after its transfer,
//   from the event register. The rate is set by the single decode pass
//   between the sequence state registers and that event register.
// Stall:
//   key_bytes.ready is high while the event register is empty or is being
//   taken in the same cycle, so a stalled receiver holds the event and
//   stops input only once an event is waiting.
// Reset:
//   rst (synchronous) clears all escape and UTF-8 state and empties the
//   event register. A lone ESC waits for its next byte with no timeout.
module terminal_key_event_decoder
  import tked_pkg::*;
#(
  parameter int MAX_ESCAPE_LENGTH = MAX_ESCAPE_LENGTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  tked_byte_if.sink    key_bytes,
  tked_event_if.source key_events
);

  typedef struct packed {
    logic              hit;
    logic [KEY_W-1:0]  code;
  } key_lookup_t;

  // Sequence state.
  logic [LEN_W-1:0]  escape_length, escape_length_next;
  logic [BYTE_W-1:0] escape_second_byte, escape_second_byte_next;
  logic [BYTE_W-1:0] escape_param0, escape_param0_next;
  logic [BYTE_W-1:0] escape_param1, escape_param1_next;
  logic [1:0]        escape_param_count, escape_param_count_next;
  logic              semicolon_seen, semicolon_seen_next;
  logic [BYTE_W-1:0] modifier_byte, modifier_byte_next;
  logic              modifier_captured, modifier_captured_next;
  logic [CHAR_W-1:0] utf8_codepoint, utf8_codepoint_next;
  logic [1:0]        utf8_remaining, utf8_remaining_next;

  // Event register.
  logic              ev_valid;
  logic [KEY_W-1:0]  ev_key;
  logic [CHAR_W-1:0] ev_char;
  logic              ev_ctrl, ev_alt, ev_shift;

  // Decode result for the byte in flight.
  logic              res_valid;
  logic [KEY_W-1:0]  res_key;
  logic [CHAR_W-1:0] res_char;
  logic              res_ctrl, res_alt, res_shift;

  logic [BYTE_W-1:0] b;
  logic              accept;
  logic [LEN_W-1:0]  len;
  logic [CHAR_W-1:0] cp;
  logic [2:0]        mod_value;
  logic              fresh;
  key_lookup_t       cur_hit;
  key_lookup_t       tilde_hit;
  key_lookup_t       ss3_hit;

  function automatic key_lookup_t cursor_key(input logic [BYTE_W-1:0] c);
    key_lookup_t r;
    r.hit = 1'b1;
    case (c)
      "A":     r.code = KEY_UP;
      "B":     r.code = KEY_DOWN;
      "C":     r.code = KEY_RIGHT;
      "D":     r.code = KEY_LEFT;
      "H":     r.code = KEY_HOME;
      "F":     r.code = KEY_END;
      default: begin
        r.hit  = 1'b0;
        r.code = KEY_CHAR;
      end
    endcase
    return r;
  endfunction

  // Tilde keys: one parameter digit at length four, two digits at length five.
  function automatic key_lookup_t tilde_key(input logic [LEN_W-1:0] l,
                                            input logic [BYTE_W-1:0] p0,
                                            input logic [BYTE_W-1:0] p1);
    key_lookup_t r;
    r.hit  = 1'b0;
    r.code = KEY_CHAR;
    if (l == LEN_W'(4)) begin
      r.hit = 1'b1;
      case (p0)
        "1":     r.code = KEY_HOME;
        "2":     r.code = KEY_INS;
        "3":     r.code = KEY_DEL;
        "4":     r.code = KEY_END;
        "5":     r.code = KEY_PGUP;
        "6":     r.code = KEY_PGDN;
        default: r.hit  = 1'b0;
      endcase
    end else if (l == LEN_W'(5)) begin
      r.hit = 1'b1;
      if (p0 == "1") begin
        case (p1)
          "5":     r.code = KEY_F5;
          "7":     r.code = KEY_F6;
          "8":     r.code = KEY_F7;
          "9":     r.code = KEY_F8;
          default: r.hit  = 1'b0;
        endcase
      end else if (p0 == "2") begin
        case (p1)
          "0":     r.code = KEY_F9;
          "1":     r.code = KEY_F10;
          "3":     r.code = KEY_F11;
          "4":     r.code = KEY_F12;
          default: r.hit  = 1'b0;
        endcase
      end else begin
        r.hit = 1'b0;
      end
    end
    return r;
  endfunction

  // SS3 finals: F1..F4 and the arrows; home and end are not taken here.
  function automatic key_lookup_t ss3_key(input logic [BYTE_W-1:0] c);
    key_lookup_t r;
    r.hit = 1'b1;
    case (c)
      "P":     r.code = KEY_F1;
      "Q":     r.code = KEY_F2;
      "R":     r.code = KEY_F3;
      "S":     r.code = KEY_F4;
      "A":     r.code = KEY_UP;
      "B":     r.code = KEY_DOWN;
      "C":     r.code = KEY_RIGHT;
      "D":     r.code = KEY_LEFT;
      default: begin
        r.hit  = 1'b0;
        r.code = KEY_CHAR;
      end
    endcase
    return r;
  endfunction

  assign b      = key_bytes.in_byte;
  assign accept = key_bytes.valid && key_bytes.ready;
  assign key_bytes.ready = !ev_valid || key_events.ready;

  always_comb begin
    escape_length_next      = escape_length;
    escape_second_byte_next = escape_second_byte;
    escape_param0_next      = escape_param0;
    escape_param1_next      = escape_param1;
    escape_param_count_next = escape_param_count;
    semicolon_seen_next     = semicolon_seen;
    modifier_byte_next      = modifier_byte;
    modifier_captured_next  = modifier_captured;
    utf8_codepoint_next     = utf8_codepoint;
    utf8_remaining_next     = utf8_remaining;

    res_valid = 1'b0;
    res_key   = KEY_CHAR;
    res_char  = '0;
    res_ctrl  = 1'b0;
    res_alt   = 1'b0;
    res_shift = 1'b0;

    len       = (escape_length < LEN_W'(63)) ? escape_length + LEN_W'(1) : escape_length;
    cp        = {utf8_codepoint[CHAR_W-7:0], b[5:0]};
    mod_value = 3'(modifier_byte_next - 8'h31);
    fresh     = 1'b0;
    cur_hit   = cursor_key(b);
    ss3_hit   = ss3_key(b);

    // Parameter capture comes first so that the final checks see it.
    if (escape_length != '0 && len != LEN_W'(2) && escape_second_byte == "[") begin
      if (len <= LEN_W'(4) && escape_param_count < 2'd2) begin
        if (len == LEN_W'(3)) begin
          escape_param0_next = b;
        end else begin
          escape_param1_next = b;
        end
        escape_param_count_next = escape_param_count + 2'd1;
      end
      if (semicolon_seen) begin
        if (!modifier_captured) begin
          modifier_byte_next     = b;
          modifier_captured_next = 1'b1;
        end
      end else if (b == ";") begin
        semicolon_seen_next = 1'b1;
      end
    end
    mod_value = 3'(modifier_byte_next - 8'h31);
    tilde_hit = tilde_key(len, escape_param0_next, escape_param1_next);

    if (escape_length != '0) begin
      escape_length_next = len;
      if (len == LEN_W'(2)) begin
        escape_second_byte_next = b;
        if (b != "[" && b != "O") begin
          escape_length_next      = '0;
          escape_second_byte_next = '0;
          res_valid = 1'b1;
          res_char  = CHAR_W'(b);
          res_alt   = 1'b1;
        end
      end else if (escape_second_byte == "[") begin
        if (len == LEN_W'(3) && b == "Z") begin
          escape_length_next = '0;
          res_valid = 1'b1;
          res_key   = KEY_TAB;
          res_shift = 1'b1;
        end else if (len == LEN_W'(3) && cur_hit.hit) begin
          escape_length_next = '0;
          res_valid = 1'b1;
          res_key   = cur_hit.code;
        end else if (b == "~") begin
          escape_length_next = '0;
          res_valid = tilde_hit.hit;
          res_key   = tilde_hit.code;
        end else if (len >= LEN_W'(6) && modifier_captured_next) begin
          escape_length_next = '0;
          res_valid = cur_hit.hit;
          res_key   = cur_hit.code;
          // Modifier digits 2..8 encode shift, alt and ctrl as value minus one.
          if (modifier_byte_next >= "2" && modifier_byte_next <= "8") begin
            res_shift = mod_value[0];
            res_alt   = mod_value[1];
            res_ctrl  = mod_value[2];
          end
        end else if (len > LEN_W'(MAX_ESCAPE_LENGTH)) begin
          escape_length_next = '0;
          res_valid = 1'b1;
          res_key   = KEY_ESC;
        end
      end else if (len == LEN_W'(3)) begin
        escape_length_next = '0;
        res_valid = ss3_hit.hit;
        res_key   = ss3_hit.code;
      end else if (len > LEN_W'(MAX_ESCAPE_LENGTH)) begin
        escape_length_next = '0;
        res_valid = 1'b1;
        res_key   = KEY_ESC;
      end

      // Ending a sequence clears everything it gathered.
      if (escape_length_next == '0) begin
        escape_second_byte_next = '0;
        escape_param0_next      = '0;
        escape_param1_next      = '0;
        escape_param_count_next = '0;
        semicolon_seen_next     = 1'b0;
        modifier_byte_next      = '0;
        modifier_captured_next  = 1'b0;
      end
    end else begin
      fresh = 1'b1;
      if (utf8_remaining != 2'd0) begin
        if (b[7:6] == 2'b10) begin
          fresh               = 1'b0;
          utf8_remaining_next = utf8_remaining - 2'd1;
          if (utf8_remaining == 2'd1) begin
            utf8_codepoint_next = '0;
            if (!(cp > CP_MAX || (cp >= CP_SURR_LOW && cp <= CP_SURR_HIGH))) begin
              res_valid = 1'b1;
              res_char  = cp;
            end
          end else begin
            utf8_codepoint_next = cp;
          end
        end else begin
          // A broken sequence is dropped and the byte is decoded on its own.
          utf8_remaining_next = 2'd0;
          utf8_codepoint_next = '0;
        end
      end

      if (fresh) begin
        if (b == BYTE_ESC) begin
          escape_length_next = LEN_W'(1);
        end else if (b == BYTE_CR || b == BYTE_LF) begin
          res_valid = 1'b1;
          res_key   = KEY_ENTER;
        end else if (b == BYTE_TAB) begin
          res_valid = 1'b1;
          res_key   = KEY_TAB;
        end else if (b == BYTE_BS || b == BYTE_DEL) begin
          res_valid = 1'b1;
          res_key   = KEY_BKSP;
        end else if (b >= 8'd1 && b <= BYTE_SUB) begin
          res_valid = 1'b1;
          res_char  = CHAR_W'(b + 8'h60);
          res_ctrl  = 1'b1;
        end else if (!b[7]) begin
          res_valid = 1'b1;
          res_char  = CHAR_W'(b);
        end else if (b[7:5] == 3'b110) begin
          utf8_codepoint_next = CHAR_W'(b[4:0]);
          utf8_remaining_next = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          utf8_codepoint_next = CHAR_W'(b[3:0]);
          utf8_remaining_next = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          utf8_codepoint_next = CHAR_W'(b[2:0]);
          utf8_remaining_next = 2'd3;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_length      <= '0;
      escape_second_byte <= '0;
      escape_param0      <= '0;
      escape_param1      <= '0;
      escape_param_count <= '0;
      semicolon_seen     <= 1'b0;
      modifier_byte      <= '0;
      modifier_captured  <= 1'b0;
      utf8_codepoint     <= '0;
      utf8_remaining     <= '0;
      ev_valid           <= 1'b0;
    end else if (accept) begin
      escape_length      <= escape_length_next;
      escape_second_byte <= escape_second_byte_next;
      escape_param0      <= escape_param0_next;
      escape_param1      <= escape_param1_next;
      escape_param_count <= escape_param_count_next;
      semicolon_seen     <= semicolon_seen_next;
      modifier_byte      <= modifier_byte_next;
      modifier_captured  <= modifier_captured_next;
      utf8_codepoint     <= utf8_codepoint_next;
      utf8_remaining     <= utf8_remaining_next;
      ev_valid           <= res_valid;
    end else if (key_events.ready) begin
      ev_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      ev_key   <= res_key;
      ev_char  <= res_char;
      ev_ctrl  <= res_ctrl;
      ev_alt   <= res_alt;
      ev_shift <= res_shift;
    end
  end

  assign key_events.valid     = ev_valid;
  assign key_events.key_code  = ev_key;
  assign key_events.character = ev_char;
  assign key_events.ctrl      = ev_ctrl;
  assign key_events.alt       = ev_alt;
  assign key_events.shift     = ev_shift;

endmodule

// File: dv/terminal_key_event_decoder_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for terminal_key_event_decoder: feeds raw terminal bytes,
// decodes them with its own key decoder and compares every key event the block sends.
// Depends on tked_pkg, tked_byte_if, tked_event_if and terminal_key_event_decoder.
module terminal_key_event_decoder_test;
  import tked_pkg::*;

  localparam int BYTE_COUNT   = 1850;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RESET_CYCLES = 11;
  localparam logic [LEN_W-1:0] LEN_SAT = '1;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [CHAR_W-1:0] ch;
    logic              ctrl;
    logic              alt;
    logic              shift;
  } key_event_t;

  class key_event_tracker;
    logic [LEN_W-1:0]  esc_len;
    logic [BYTE_W-1:0] esc_second;
    logic [BYTE_W-1:0] esc_params [2];
    bit                semi_seen;
    logic [BYTE_W-1:0] mod_byte;
    bit                mod_captured;
    logic [CHAR_W-1:0] utf_cp;
    int unsigned       utf_left;
    key_event_t        expected_events [$];
    int unsigned       failures;

    function new();
      clear_escape();
      utf_cp   = '0;
      utf_left = 0;
      failures = 0;
    endfunction

    function void clear_escape();
      esc_len       = '0;
      esc_second    = '0;
      esc_params[0] = '0;
      esc_params[1] = '0;
      semi_seen     = 1'b0;
      mod_byte      = '0;
      mod_captured  = 1'b0;
    endfunction

    function bit cursor_code(input logic [BYTE_W-1:0] b, output logic [KEY_W-1:0] k);
      k = KEY_CHAR;
      case (b)
        "A": k = KEY_UP;
        "B": k = KEY_DOWN;
        "C": k = KEY_RIGHT;
        "D": k = KEY_LEFT;
        "H": k = KEY_HOME;
        "F": k = KEY_END;
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function bit tilde_code(input logic [LEN_W-1:0] len, output logic [KEY_W-1:0] k);
      k = KEY_CHAR;
      if (len == 4) begin
        case (esc_params[0])
          "1": k = KEY_HOME;
          "2": k = KEY_INS;
          "3": k = KEY_DEL;
          "4": k = KEY_END;
          "5": k = KEY_PGUP;
          "6": k = KEY_PGDN;
          default: return 1'b0;
        endcase
        return 1'b1;
      end
      if (len == 5) begin
        if (esc_params[0] == "1") begin
          case (esc_params[1])
            "5": k = KEY_F5;
            "7": k = KEY_F6;
            "8": k = KEY_F7;
            "9": k = KEY_F8;
            default: return 1'b0;
          endcase
        end else if (esc_params[0] == "2") begin
          case (esc_params[1])
            "0": k = KEY_F9;
            "1": k = KEY_F10;
            "3": k = KEY_F11;
            "4": k = KEY_F12;
            default: return 1'b0;
          endcase
        end else begin
          return 1'b0;
        end
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit escape_step(input logic [BYTE_W-1:0] b, output key_event_t ev);
      logic [LEN_W-1:0]  len;
      logic [KEY_W-1:0]  k;
      logic [BYTE_W-1:0] mod_val;
      bit                found;
      ev = '0;
      if (esc_len != LEN_SAT) esc_len++;
      len = esc_len;

      if (len == 2) begin
        esc_second = b;
        if (b != "[" && b != "O") begin
          clear_escape();
          ev.ch  = CHAR_W'(b);
          ev.alt = 1'b1;
          return 1'b1;
        end
        return 1'b0;
      end

      if (esc_second == "[") begin
        if (len <= 4) esc_params[len - 3] = b;
        if (semi_seen) begin
          if (!mod_captured) begin
            mod_byte     = b;
            mod_captured = 1'b1;
          end
        end else if (b == ";") begin
          semi_seen = 1'b1;
        end

        if (len == 3) begin
          if (b == "Z") begin
            clear_escape();
            ev.key   = KEY_TAB;
            ev.shift = 1'b1;
            return 1'b1;
          end
          if (cursor_code(b, k)) begin
            clear_escape();
            ev.key = k;
            return 1'b1;
          end
        end
        // A tilde always closes the sequence, known key or not.
        if (b == "~") begin
          found = tilde_code(len, k);
          clear_escape();
          ev.key = k;
          return found;
        end
        if (len >= 6 && mod_captured) begin
          if (mod_byte >= "2" && mod_byte <= "8") begin
            mod_val  = mod_byte - "1";
            ev.shift = mod_val[0];
            ev.alt   = mod_val[1];
            ev.ctrl  = mod_val[2];
          end
          found = cursor_code(b, k);
          clear_escape();
          if (!found) begin
            ev = '0;
            return 1'b0;
          end
          ev.key = k;
          return 1'b1;
        end
      end else if (len == 3) begin
        found = 1'b1;
        case (b)
          "P": k = KEY_F1;
          "Q": k = KEY_F2;
          "R": k = KEY_F3;
          "S": k = KEY_F4;
          default: begin
            found = cursor_code(b, k);
            if (k == KEY_HOME || k == KEY_END) found = 1'b0;
          end
        endcase
        clear_escape();
        ev.key = k;
        return found;
      end

      if (len > MAX_ESCAPE_LENGTH_DEFAULT) begin
        clear_escape();
        ev.key = KEY_ESC;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit decode_byte(input logic [BYTE_W-1:0] b, output key_event_t ev);
      logic [CHAR_W-1:0] cp;
      logic [BYTE_W-1:0] letter;
      ev = '0;
      if (esc_len != 0) return escape_step(b, ev);

      if (utf_left != 0) begin
        if (b[7:6] == 2'b10) begin
          utf_cp = {utf_cp[CHAR_W-7:0], b[5:0]};
          utf_left--;
          if (utf_left == 0) begin
            cp     = utf_cp;
            utf_cp = '0;
            if (cp > CP_MAX || (cp >= CP_SURR_LOW && cp <= CP_SURR_HIGH)) return 1'b0;
            ev.ch = cp;
            return 1'b1;
          end
          return 1'b0;
        end
        // Broken sequence: drop what was gathered and decode this byte afresh.
        utf_left = 0;
        utf_cp   = '0;
      end

      if (b == BYTE_ESC) begin
        esc_len = 1;
        return 1'b0;
      end
      if (b == BYTE_CR || b == BYTE_LF) begin
        ev.key = KEY_ENTER;
        return 1'b1;
      end
      if (b == BYTE_TAB) begin
        ev.key = KEY_TAB;
        return 1'b1;
      end
      if (b == BYTE_BS || b == BYTE_DEL) begin
        ev.key = KEY_BKSP;
        return 1'b1;
      end
      if (b >= 1 && b <= BYTE_SUB) begin
        letter  = b + "a" - 8'd1;
        ev.ch   = CHAR_W'(letter);
        ev.ctrl = 1'b1;
        return 1'b1;
      end
      if (!b[7]) begin
        ev.ch = CHAR_W'(b);
        return 1'b1;
      end

      if (b[7:5] == 3'b110) begin
        utf_cp   = CHAR_W'(b[4:0]);
        utf_left = 1;
      end else if (b[7:4] == 4'b1110) begin
        utf_cp   = CHAR_W'(b[3:0]);
        utf_left = 2;
      end else if (b[7:3] == 5'b11110) begin
        utf_cp   = CHAR_W'(b[2:0]);
        utf_left = 3;
      end
      return 1'b0;
    endfunction

    function void note_byte(input logic [BYTE_W-1:0] b);
      key_event_t ev;
      if (decode_byte(b, ev)) expected_events = {expected_events, ev};
    endfunction

    function void check_event(input key_event_t got);
      key_event_t want;
      if (expected_events.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: unexpected event key=%0d char=%h ctrl=%b alt=%b shift=%b",
                   got.key, got.ch, got.ctrl, got.alt, got.shift);
        return;
      end
      want = expected_events.pop_front();
      if (got.key !== want.key || got.ch !== want.ch || got.ctrl !== want.ctrl ||
          got.alt !== want.alt || got.shift !== want.shift) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: expected key=%0d char=%h cas=%b%b%b, got key=%0d char=%h cas=%b%b%b",
                   want.key, want.ch, want.ctrl, want.alt, want.shift,
                   got.key, got.ch, got.ctrl, got.alt, got.shift);
      end
    endfunction

    function int unsigned waiting();
      return expected_events.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   calm;
  int unsigned idle_cycles;
  logic [BYTE_W-1:0] stim_q [$];
  key_event_tracker tracker = new();

  tked_byte_if  key_bytes ();
  tked_event_if key_events ();

  terminal_key_event_decoder dut (
    .clk(clk),
    .rst(rst),
    .key_bytes(key_bytes),
    .key_events(key_events)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one; none at all during calm stretches.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_from(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic void queue_byte(input logic [BYTE_W-1:0] v);
    stim_q = {stim_q, v};
  endfunction

  function automatic logic [CHAR_W-1:0] pick_codepoint(input int unsigned n);
    if (n == 2) return CHAR_W'($urandom_range(0, 'h7FF));
    if (n == 3) begin
      if ($urandom_range(0, 3) == 0)
        return CHAR_W'($urandom_range(CP_SURR_LOW, CP_SURR_HIGH));
      return CHAR_W'($urandom_range(0, 'hFFFF));
    end
    if ($urandom_range(0, 3) == 0) return CHAR_W'($urandom_range('h110000, 'h1FFFFF));
    return CHAR_W'($urandom_range(0, CP_MAX));
  endfunction

  // Queues the first 'keep' bytes of the n-byte UTF-8 form of cp.
  function automatic void push_utf8(input int unsigned n, input logic [CHAR_W-1:0] cp,
                                    input int unsigned keep);
    logic [BYTE_W-1:0] enc [4];
    enc[0] = '0;
    enc[1] = '0;
    enc[2] = '0;
    enc[3] = '0;
    case (n)
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int unsigned i = 0; i < keep; i++) queue_byte(enc[i]);
  endfunction

  function automatic void build_sequence(input int unsigned kind);
    int unsigned n;
    if (kind < 15) begin
      queue_byte(BYTE_W'($urandom_range(0, 127)));
    end else if (kind < 20) begin
      repeat ($urandom_range(1, 3)) queue_byte(rand_byte());
    end else if (kind < 30) begin
      queue_byte(BYTE_ESC);
      queue_byte(rand_byte());
    end else if (kind < 42) begin
      queue_byte(BYTE_ESC);
      queue_byte("[");
      queue_byte(($urandom_range(0, 4) == 0) ? rand_byte() : pick_from("ABCDHFZ"));
    end else if (kind < 54) begin
      queue_byte(BYTE_ESC);
      queue_byte("[");
      queue_byte(pick_from("0123456"));
      repeat ($urandom_range(0, 2)) queue_byte(pick_from("0123456789"));
      queue_byte(($urandom_range(0, 7) == 0) ? rand_byte() : BYTE_W'("~"));
    end else if (kind < 66) begin
      queue_byte(BYTE_ESC);
      queue_byte("[");
      queue_byte(pick_from("1123"));
      queue_byte(";");
      queue_byte(($urandom_range(0, 3) == 0) ? pick_from("019") : pick_from("2345678"));
      queue_byte(($urandom_range(0, 5) == 0) ? rand_byte() : pick_from("ABCDHF"));
    end else if (kind < 74) begin
      queue_byte(BYTE_ESC);
      queue_byte("O");
      queue_byte(($urandom_range(0, 5) == 0) ? rand_byte() : pick_from("PQRSABCDHF"));
    end else if (kind < 90) begin
      n = $urandom_range(2, 4);
      push_utf8(n, pick_codepoint(n), n);
    end else if (kind < 96) begin
      // Truncated UTF-8 followed by an arbitrary byte.
      n = $urandom_range(2, 4);
      push_utf8(n, pick_codepoint(n), $urandom_range(1, n - 1));
      queue_byte(rand_byte());
    end else if (kind < 98) begin
      queue_byte(BYTE_ESC);
      queue_byte("[");
      repeat ($urandom_range(1, 6))
        queue_byte(($urandom_range(0, 3) == 0) ? rand_byte()
                                                : pick_from("0123456789;~ABZ"));
    end else begin
      // Digits never close a CSI sequence, so this can run past the length limit.
      queue_byte(BYTE_ESC);
      queue_byte("[");
      repeat ($urandom_range(29, 34)) queue_byte(pick_from("0123456789"));
    end
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      key_bytes.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    key_bytes.valid   <= 1'b1;
    key_bytes.in_byte <= b;
    @(posedge clk);
    while (!key_bytes.ready) @(posedge clk);
  endtask

  task automatic run_receiver();
    int unsigned gap;
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        key_events.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      key_events.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Results are checked before the byte taken at the same edge is noted;
  // an event always leaves in a later cycle than its byte.
  always @(posedge clk) begin
    if (!rst) begin
      if (key_events.valid && key_events.ready)
        tracker.check_event('{key_events.key_code, key_events.character, key_events.ctrl,
                              key_events.alt, key_events.shift});
      if (key_bytes.valid && key_bytes.ready)
        tracker.note_byte(key_bytes.in_byte);
    end
  end

  always @(posedge clk) begin
    if (rst || (key_bytes.valid && key_bytes.ready) ||
        (key_events.valid && key_events.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned seq_no;
    key_bytes.valid   <= 1'b0;
    key_bytes.in_byte <= '0;
    key_events.ready  <= 1'b0;
    idle_cycles       <= 0;
    calm = 1'b0;
    sent = 0;
    seq_no = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    fork
      run_receiver();
    join_none

    // Directed bytes: field extremes, control keys, alt+ESC, a modified cursor key,
    // SS3 F1, a surrogate, a stray continuation and a broken two-byte sequence.
    stim_q = '{8'h00, 8'hFF, 8'h01, BYTE_SUB, BYTE_BS, BYTE_TAB, BYTE_CR, BYTE_DEL,
               BYTE_ESC, BYTE_ESC,
               BYTE_ESC, "[", "1", ";", "5", "C",
               BYTE_ESC, "O", "P",
               8'hED, 8'hA0, 8'h80, 8'h80, 8'hC3, "A"};
    while (sent < BYTE_COUNT) begin
      if (stim_q.size() == 0) begin
        build_sequence((seq_no == 0) ? 99 : $urandom_range(0, 99));
        seq_no++;
        if ($urandom_range(0, 19) == 0) calm = !calm;
      end
      send_byte(stim_q.pop_front());
      sent++;
    end
    key_bytes.valid <= 1'b0;

    // One more edge so the last transfer has surely been noted.
    @(posedge clk);
    while (tracker.waiting() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.failures == 0 && tracker.waiting() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
